[rtl/lrufr_pkg.sv]
// Shared constants, control types and state encoding for the LRU frame replacement block.
package lrufr_pkg;

    localparam int FRAMES  = 64;
    localparam int FRAME_W = 6;
    localparam int POS_W   = $clog2(FRAMES);
    localparam int CNT_W   = 7;

    localparam int RESET_COUNT = (64 > FRAMES) ? FRAMES : 64;
    localparam logic [POS_W-1:0] RESET_LAST = POS_W'(RESET_COUNT - 1);
    localparam logic [CNT_W-1:0] MAX_COUNT  = CNT_W'(FRAMES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SELECT
    } t_state;

    typedef struct packed {
        logic               restart;
        logic               load_match;
        logic               shift;
        logic [FRAME_W-1:0] frame;
        logic [POS_W-1:0]   last_pos;
    } t_cell_ctl;

endpackage

[rtl/lrufr_cell.sv]
// One position of the recency stack: holds a frame number and hands it down on a move-to-front.
module lrufr_cell
    import lrufr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [FRAME_W-1:0] i_prev_frame,
    input  logic               i_found,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_found,
    output logic [FRAME_W-1:0] o_tap
);

    logic [FRAME_W-1:0] r_frame;
    logic               r_last;
    logic               r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FRAME_W'(i_pos);
            r_last  <= (i_pos == RESET_LAST);
            r_match <= 1'b0;
        end else if (i_ctl.restart) begin
            r_frame <= FRAME_W'(i_pos);
            r_last  <= (i_pos == i_ctl.last_pos);
            r_match <= 1'b0;
        end else begin
            if (i_ctl.load_match) begin
                r_match <= (r_frame == i_ctl.frame);
            end
            // shift down while the referenced frame sits at or below this position
            if (i_ctl.shift && !i_found) begin
                r_frame <= i_prev_frame;
            end
        end
    end

    assign o_frame = r_frame;
    assign o_found = i_found | r_match;
    assign o_tap   = r_last ? r_frame : '0;

endmodule

[rtl/lrufr_row.sv]
// Chain of recency cells, most recent first, with the victim tap gathered from the last position.
module lrufr_row
    import lrufr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    output logic [FRAME_W-1:0] o_victim
);

    logic [FRAME_W-1:0] w_frame [FRAMES];
    logic [FRAME_W-1:0] w_tap   [FRAMES];
    logic               w_found [FRAMES];

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            logic [FRAME_W-1:0] w_prev;
            logic               w_prev_found;

            if (g == 0) begin : g_head
                assign w_prev       = i_ctl.frame;
                assign w_prev_found = 1'b0;
            end else begin : g_body
                assign w_prev       = w_frame[g-1];
                assign w_prev_found = w_found[g-1];
            end

            lrufr_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_pos        (POS_W'(g)),
                .i_prev_frame (w_prev),
                .i_found      (w_prev_found),
                .o_frame      (w_frame[g]),
                .o_found      (w_found[g]),
                .o_tap        (w_tap[g])
            );
        end
    endgenerate

    // exactly one cell carries the last-position mark, others tap zero
    always_comb begin
        o_victim = '0;
        for (int k = 0; k < FRAMES; k++) begin
            o_victim = o_victim | w_tap[k];
        end
    end

endmodule

[rtl/lru_frame_replacement.sv]
// Top level of the LRU frame replacement block: handshake, control sequencer and result register.
//
// Usage:
//   Command channel: drive i_frame_index with start high; the beat is taken at a rising edge
//   where start is high and busy is low. busy rises the cycle after and stays high while the
//   stack updates.
//   Result: o_valid pulses for one cycle with o_victim_frame (least recently used frame after
//   the update) and o_index_error. The receiver cannot hold a result off.
//   Sequence of three steps after the accepting edge: each cell registers its compare
//   (match), the row shifts (shift), and the last-position tap is registered together
//   with o_valid (select); the result beat is taken at the edge that ends the o_valid
//   cycle. A new reference is not taken while one is in flight; the next start may be
//   taken in the very cycle the previous result strobes.
//   Configuration: a beat on i_cfg_valid/o_cfg_ready writes frames_in_use (0 reads as 1,
//   above FRAMES saturates) and restarts the order with frame i at position i. o_cfg_ready
//   is high only while no reference is in flight and start is low; a reference wins the edge.
//   Reset (synchronous, active low): frames_in_use returns to 64 and the order to identity;
//   no clearing pass is needed because every cell resets in place.
//   A frame index at or beyond frames_in_use leaves the order unchanged and sets the error bit.
module lru_frame_replacement
    import lrufr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FRAME_W-1:0] i_frame_index,
    output logic               o_valid,
    output logic [FRAME_W-1:0] o_victim_frame,
    output logic               o_index_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_err, n_err;
    logic               r_valid, n_valid;
    logic [FRAME_W-1:0] r_victim, n_victim;

    t_cell_ctl          w_ctl;
    logic [FRAME_W-1:0] w_victim;
    logic               w_accept;
    logic               w_cfg_write;
    logic [CNT_W-1:0]   w_cfg_count;
    logic [POS_W-1:0]   w_last_full;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !start;
    assign w_accept    = start && !busy;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // clamp the written count into 1..FRAMES
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_count = CNT_W'(1);
        end else if (i_cfg_data > MAX_COUNT) begin
            w_cfg_count = MAX_COUNT;
        end else begin
            w_cfg_count = i_cfg_data;
        end
    end

    assign w_last_full = POS_W'(w_cfg_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= CNT_W'(RESET_COUNT);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame  <= n_frame;
        r_err    <= n_err;
        r_victim <= n_victim;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_frame  = r_frame;
        n_err    = r_err;
        n_valid  = 1'b0;
        n_victim = r_victim;

        w_ctl.restart    = 1'b0;
        w_ctl.load_match = 1'b0;
        w_ctl.shift      = 1'b0;
        w_ctl.frame      = r_frame;
        w_ctl.last_pos   = w_last_full;

        case (r_state)
            ST_IDLE: begin
                if (w_cfg_write) begin
                    // restart the order and move the last-position mark
                    n_count       = w_cfg_count;
                    w_ctl.restart = 1'b1;
                end else if (w_accept) begin
                    // latch the beat and let every cell compare against it
                    n_frame          = i_frame_index;
                    n_err            = ({1'b0, i_frame_index} >= r_count);
                    w_ctl.frame      = i_frame_index;
                    w_ctl.load_match = 1'b1;
                    n_state          = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // drop the update for an out-of-range index
                w_ctl.shift = !r_err;
                n_state     = ST_SELECT;
            end
            ST_SELECT: begin
                n_victim = w_victim;
                n_valid  = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    lrufr_row u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_victim (w_victim)
    );

    assign o_valid        = r_valid;
    assign o_victim_frame = r_victim;
    assign o_index_error  = r_err;

endmodule

[sim/lru_frame_replacement_checker.sv]
// Checker for the LRU frame replacement block: mirrors the recency order and scores each result.
`timescale 1ns / 100ps

module lru_frame_replacement_checker
    import lrufr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic               i_valid,
    input  logic [FRAME_W-1:0] i_victim_frame,
    input  logic               i_index_error,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [FRAME_W-1:0] victim;
        logic               index_error;
    } t_eviction;

    logic [FRAME_W-1:0] recency [FRAMES];
    int                 managed = RESET_COUNT;
    t_eviction          evictions_due [$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic restart_order;
        for (int i = 0; i < FRAMES; i++) recency[i] = FRAME_W'(i);
    endtask

    always @(posedge i_clk) begin : track_order
        t_eviction want;
        int        pos;
        if (!i_rst_n) begin
            restart_order();
            managed = RESET_COUNT;
            evictions_due.delete();
        end else begin
            // Score the result beat before this edge's reference is folded in.
            if (i_valid) begin
                if (evictions_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: victim %0d error %0b",
                                 i_victim_frame, i_index_error);
                    fail_count++;
                end else begin
                    want = evictions_due.pop_front();
                    if (want.victim !== i_victim_frame ||
                        want.index_error !== i_index_error) begin
                        if (fail_count < 10)
                            $display("mismatch: victim exp %0d got %0d, error exp %0b got %0b",
                                     want.victim, i_victim_frame,
                                     want.index_error, i_index_error);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_data == '0)
                    managed = 1;
                else if (i_cfg_data > MAX_COUNT)
                    managed = FRAMES;
                else
                    managed = int'(i_cfg_data);
                restart_order();
            end
            if (i_start && !i_busy) begin
                want.index_error = (int'(i_frame_index) >= managed);
                if (!want.index_error) begin
                    pos = 0;
                    while (pos < managed - 1 && recency[pos] != i_frame_index) pos++;
                    for (; pos > 0; pos--) recency[pos] = recency[pos - 1];
                    recency[0] = i_frame_index;
                end
                want.victim = recency[managed - 1];
                evictions_due.push_back(want);
            end
        end
        o_pending <= evictions_due.size();
    end

endmodule

[sim/lru_frame_replacement_tb.sv]
// Testbench top for the LRU frame replacement block: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module lru_frame_replacement_tb;
    import lrufr_pkg::*;

    localparam int ITEMS        = 1600;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic [FRAME_W-1:0] i_frame_index = '0;
    logic               o_valid;
    logic [FRAME_W-1:0] o_victim_frame;
    logic               o_index_error;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data    = '0;

    int                 fail_count;
    int                 pending;
    int                 sender_idle_pct = 0;
    int                 active_count    = RESET_COUNT;
    int                 stall_cycles    = 0;
    logic [FRAME_W-1:0] last_frame      = '0;

    always #5 i_clk = ~i_clk;

    lru_frame_replacement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_frame_index  (i_frame_index),
        .o_valid        (o_valid),
        .o_victim_frame (o_victim_frame),
        .o_index_error  (o_index_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    lru_frame_replacement_checker order_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_frame_index  (i_frame_index),
        .i_valid        (o_valid),
        .i_victim_frame (o_victim_frame),
        .i_index_error  (o_index_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one reference beat, after a random gap, and hold it until the block takes it.
    // Start stays high on return, so back-to-back beats never drop it within one step.
    task automatic send_reference(input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_frame_index <= frame;
        do @(posedge i_clk); while (busy);
        if (int'(frame) < active_count) last_frame = frame;
    endtask

    // Drop start and hold off until every predicted victim has come back.
    task automatic settle;
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write frames_in_use once the block is quiet; the order restarts at identity.
    task automatic write_frames_in_use(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (value == '0)
            active_count = 1;
        else if (value > MAX_COUNT)
            active_count = FRAMES;
        else
            active_count = int'(value);
        last_frame = '0;
    endtask

    initial begin : stimulus
        int                 sent;
        int                 burst;
        int                 r;
        logic [CNT_W-1:0]   cfg_value;
        logic [FRAME_W-1:0] frame;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset size, touch the most recent frame, the top frame, alternating bits.
        send_reference(6'd0);
        send_reference(6'd0);
        send_reference(6'd63);
        send_reference(6'd63);
        send_reference(6'd1);
        send_reference(6'd21);
        send_reference(6'd42);
        send_reference(6'd62);
        send_reference(6'd5);

        // Zero reads as one frame: only frame 0 is legal, all else flags an error.
        write_frames_in_use(7'd0);
        send_reference(6'd0);
        send_reference(6'd0);
        send_reference(6'd1);
        send_reference(6'd63);

        // Values past the frame count saturate.
        write_frames_in_use(7'd127);
        send_reference(6'd63);
        send_reference(6'd0);
        write_frames_in_use(7'd65);
        send_reference(6'd32);

        write_frames_in_use(7'd1);
        send_reference(6'd0);
        send_reference(6'd1);

        // Small set: error just past the edge, then walk the victim around.
        write_frames_in_use(7'd3);
        send_reference(6'd2);
        send_reference(6'd3);
        send_reference(6'd1);
        send_reference(6'd0);
        send_reference(6'd2);

        write_frames_in_use(7'd64);
        send_reference(6'd0);

        // Random: sender idles 30%, then 56%, then not at all. Each burst starts from a
        // fresh size, so the pause before every write drains the pipe completely.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 56 : 0;
            sent = 0;
            while (sent < ITEMS / 3) begin
                r = $urandom_range(99);
                if (r < 25)
                    cfg_value = CNT_W'($urandom_range(4, 1));
                else if (r < 45)
                    cfg_value = CNT_W'($urandom_range(16, 5));
                else if (r < 65)
                    cfg_value = CNT_W'($urandom_range(63, 17));
                else if (r < 75)
                    cfg_value = CNT_W'(64);
                else if (r < 83)
                    cfg_value = '0;
                else if (r < 91)
                    cfg_value = CNT_W'($urandom_range(126, 65));
                else
                    cfg_value = '1;
                write_frames_in_use(cfg_value);

                burst = $urandom_range(90, 20);
                repeat (burst) begin
                    // Mostly legal frames, some repeats of the most recent, some out of range.
                    r = $urandom_range(99);
                    if (r < 10)
                        frame = last_frame;
                    else if (r < 85)
                        frame = FRAME_W'($urandom_range(active_count - 1));
                    else
                        frame = FRAME_W'($urandom_range(63));
                    send_reference(frame);
                    sent++;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[lru_frame_replacement.f]
rtl/lrufr_pkg.sv
rtl/lrufr_cell.sv
rtl/lrufr_row.sv
rtl/lru_frame_replacement.sv
sim/lru_frame_replacement_checker.sv
sim/lru_frame_replacement_tb.sv
